### rtl/sbr_pkg.sv
package sbr_pkg;

   // Block geometry: eight byte lanes, each with its own pair of 256-entry tables.
   localparam int LaneCount = 8;
   localparam int ByteW     = 8;
   localparam int TableSize = 256;
   localparam int BlockW    = LaneCount * ByteW;

   // Transaction codes on the action field.
   typedef enum logic [1:0] {
      ACT_LOAD    = 2'd0,
      ACT_ENCRYPT = 2'd1,
      ACT_DECRYPT = 2'd2,
      ACT_NONE    = 2'd3
   } action_type;

   // Table write for one lane: forward[index] = value, inverse[value] = index.
   typedef struct packed {
      logic             we;
      logic [ByteW-1:0] index;
      logic [ByteW-1:0] value;
   } load_type;

   typedef logic [ByteW-1:0] byte_type;

   // Left and right rotation of the block by one bit.
   function automatic logic [BlockW-1:0] rot_left1(input logic [BlockW-1:0] v);
      rot_left1 = {v[BlockW-2:0], v[BlockW-1]};
   endfunction

   function automatic logic [BlockW-1:0] rot_right1(input logic [BlockW-1:0] v);
      rot_right1 = {v[0], v[BlockW-1:1]};
   endfunction

endpackage

### rtl/sbox_rotate_block_cipher_unit.sv
// Encrypt or decrypt: the result is registered once the last of ROUNDS rounds
// is done; one round per cycle with all eight lane tables read in parallel.
// A new transaction is taken only once the previous block has left the round
// loop, and later while a finished result waits on a stalled result channel.
// Table loads and unused actions are taken one per cycle unless stalled; no result.
// Synchronous reset clears control state and the key; tables are undefined
// until loaded.
module sbox_rotate_block_cipher_unit
   import sbr_pkg::*;
#(
   parameter int ROUNDS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [BlockW-1:0] csr_wr_data,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_action,
   input  logic [2:0]        req_table_select,
   input  logic [7:0]        req_table_index,
   input  logic [7:0]        req_table_value,
   input  logic [BlockW-1:0] req_block_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [BlockW-1:0] rsp_result_block
);

   localparam int CountW = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
   localparam logic [CountW-1:0] LastRound = CountW'(ROUNDS - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_WAIT
   } state_type;

   state_type         state_ff;
   logic [CountW-1:0] count_ff;
   logic              dec_ff;
   logic [BlockW-1:0] hold_ff;
   logic [BlockW-1:0] key_ff;
   logic              rsp_valid_ff;
   logic [BlockW-1:0] rsp_result_block_ff;

   logic              req_accept;
   logic              start_block;
   logic              decrypt_in;
   logic              out_free;
   logic              result_load;
   logic [BlockW-1:0] round_out;
   logic [BlockW-1:0] addr_word;
   load_type          lane_load [LaneCount];
   byte_type          lane_data [LaneCount];

   // Key register.
   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else if (csr_wr_en) begin
         key_ff <= csr_wr_data;
      end
   end

   // Handshake decode.
   assign req_stall   = (state_ff != ST_IDLE);
   assign req_accept  = req_valid && !req_stall;
   assign start_block = req_accept && ((req_action == ACT_ENCRYPT) ||
                                       (req_action == ACT_DECRYPT));
   assign decrypt_in  = (state_ff == ST_IDLE) ? (req_action == ACT_DECRYPT) : dec_ff;
   assign out_free    = !rsp_valid_ff || !rsp_stall;

   // A finished block moves into the output register this cycle.
   assign result_load = out_free && (((state_ff == ST_RUN) && (count_ff == LastRound)) ||
                                     (state_ff == ST_WAIT));

   // Lanes: one byte position each, with its forward and inverse tables.
   for (genvar p = 0; p < LaneCount; p++) begin : g_lane
      always_comb begin
         lane_load[p].we    = req_accept && (req_action == ACT_LOAD) &&
                              (req_table_select == 3'(p));
         lane_load[p].index = req_table_index;
         lane_load[p].value = req_table_value;
      end

      sbr_lane u_lane (
         .clock       (clock),
         .load        (lane_load[p]),
         .rd_addr     (addr_word[BlockW-1-ByteW*p -: ByteW]),
         .use_inverse (dec_ff),
         .sub_data    (lane_data[p])
      );
   end

   // Merge the lane bytes into the round result and the next addresses.
   sbr_merge u_merge (
      .lane_data (lane_data),
      .block_in  (req_block_data),
      .use_input (state_ff == ST_IDLE),
      .decrypt   (decrypt_in),
      .key       (key_ff),
      .round_out (round_out),
      .addr_word (addr_word)
   );

   // Round sequencer and output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         dec_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && !result_load) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (start_block) begin
                  state_ff <= ST_RUN;
                  count_ff <= '0;
                  dec_ff   <= (req_action == ACT_DECRYPT);
               end
            end
            ST_RUN: begin
               if (count_ff == LastRound) begin
                  if (out_free) begin
                     rsp_valid_ff        <= 1'b1;
                     rsp_result_block_ff <= round_out;
                     state_ff            <= ST_IDLE;
                  end else begin
                     hold_ff  <= round_out;
                     state_ff <= ST_WAIT;
                  end
               end else begin
                  count_ff <= count_ff + 1'b1;
               end
            end
            ST_WAIT: begin
               if (out_free) begin
                  rsp_valid_ff        <= 1'b1;
                  rsp_result_block_ff <= hold_ff;
                  state_ff            <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_block = rsp_result_block_ff;

   // A block transaction starts the round loop at its first round.
   a_start_round: assert property (@(posedge clock) disable iff (reset)
      start_block |=> (state_ff == ST_RUN) && (count_ff == '0))
      else $error("block transaction did not start at round zero");

   // The result is only parked while the output register is still full.
   a_wait_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WAIT) |-> rsp_valid_ff)
      else $error("result parked while output register was free");

   // A new result only appears after the round loop has run.
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) != ST_IDLE))
      else $error("result produced without a running block");

endmodule

### rtl/sbr_ram.sv
module sbr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/sbr_lane.sv
module sbr_lane
   import sbr_pkg::*;
(
   input  logic     clock,
   input  load_type load,
   input  byte_type rd_addr,
   input  logic     use_inverse,
   output byte_type sub_data
);

   byte_type fwd_q;
   byte_type inv_q;

   // Forward table, written at the index with the value.
   sbr_ram #(
      .WIDTH (ByteW),
      .DEPTH (TableSize)
   ) u_fwd_ram (
      .clock   (clock),
      .wr_en   (load.we),
      .wr_addr (load.index),
      .wr_data (load.value),
      .rd_addr (rd_addr),
      .rd_data (fwd_q)
   );

   // Inverse table, written at the value with the index.
   sbr_ram #(
      .WIDTH (ByteW),
      .DEPTH (TableSize)
   ) u_inv_ram (
      .clock   (clock),
      .wr_en   (load.we),
      .wr_addr (load.value),
      .wr_data (load.index),
      .rd_addr (rd_addr),
      .rd_data (inv_q)
   );

   // Both tables are read at the same address; the direction picks one.
   assign sub_data = use_inverse ? inv_q : fwd_q;

endmodule

### rtl/sbr_merge.sv
module sbr_merge
   import sbr_pkg::*;
(
   input  byte_type          lane_data [LaneCount],
   input  logic [BlockW-1:0] block_in,
   input  logic              use_input,
   input  logic              decrypt,
   input  logic [BlockW-1:0] key,
   output logic [BlockW-1:0] round_out,
   output logic [BlockW-1:0] addr_word
);

   logic [BlockW-1:0] sub_word;
   logic [BlockW-1:0] src;

   // Gather the lane bytes back into a block, byte 0 most significant.
   always_comb begin
      sub_word = '0;
      for (int p = 0; p < LaneCount; p++) begin
         sub_word[BlockW-1-ByteW*p -: ByteW] = lane_data[p];
      end
   end

   // Finish the round: rotate after encrypt substitution, key after decrypt.
   assign round_out = decrypt ? (sub_word ^ key) : rot_left1(sub_word);

   // Table addresses for the next round come from the fresh input or the
   // block just finished.
   assign src       = use_input ? block_in : round_out;
   assign addr_word = decrypt ? rot_right1(src) : (src ^ key);

endmodule

### tb/sv/tb_sbox_rotate_block_cipher_unit.sv
module tb_sbox_rotate_block_cipher_unit;
   import sbr_pkg::*;

   localparam int CIPHER_ROUNDS  = 16;
   localparam int TABLE_DEPTH    = LaneCount * TableSize;
   localparam int DRAIN_CYCLES   = CIPHER_ROUNDS + 4;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_ITEMS   = 106;

   // Scoreboard: mirrors the lane tables and the key, and queues predicted blocks.
   class cipher_scoreboard;
      byte_type          fwd_table[TABLE_DEPTH];
      byte_type          inv_table[TABLE_DEPTH];
      logic [BlockW-1:0] cipher_key = '0;
      logic [BlockW-1:0] expected_blocks[$];
      int                errors = 0;

      task report(input string msg);
         $display("MISMATCH at %0t: %s", $time, msg);
         errors++;
      endtask

      // Per-lane byte substitution through either the forward or inverse tables.
      function logic [BlockW-1:0] substitute_lanes(input logic [BlockW-1:0] x,
                                                   input bit use_inverse);
         logic [BlockW-1:0] y;
         byte_type          b;
         logic [2:0]        lane;
         y = '0;
         for (int p = 0; p < LaneCount; p++) begin
            lane = 3'(p);
            b = x[BlockW-1-ByteW*p -: ByteW];
            y[BlockW-1-ByteW*p -: ByteW] = use_inverse ? inv_table[{lane, b}]
                                                       : fwd_table[{lane, b}];
         end
         return y;
      endfunction

      function logic [BlockW-1:0] encrypt_block(input logic [BlockW-1:0] plain);
         logic [BlockW-1:0] x;
         x = plain;
         for (int r = 0; r < CIPHER_ROUNDS; r++) begin
            x = substitute_lanes(x ^ cipher_key, 1'b0);
            x = {x[BlockW-2:0], x[BlockW-1]};
         end
         return x;
      endfunction

      function logic [BlockW-1:0] decrypt_block(input logic [BlockW-1:0] cipher);
         logic [BlockW-1:0] x;
         x = cipher;
         for (int r = 0; r < CIPHER_ROUNDS; r++) begin
            x = {x[0], x[BlockW-1:1]};
            x = substitute_lanes(x, 1'b1) ^ cipher_key;
         end
         return x;
      endfunction

      // Called once per accepted input transaction.
      function void note_request(input action_type act, input logic [2:0] lane,
                                 input byte_type idx, input byte_type val,
                                 input logic [BlockW-1:0] blk);
         case (act)
            ACT_LOAD: begin
               fwd_table[{lane, idx}] = val;
               inv_table[{lane, val}] = idx;
            end
            ACT_ENCRYPT: expected_blocks.push_back(encrypt_block(blk));
            ACT_DECRYPT: expected_blocks.push_back(decrypt_block(blk));
            default: ;
         endcase
      endfunction

      // Called once per accepted result transaction.
      task check_result(input logic [BlockW-1:0] got);
         logic [BlockW-1:0] want;
         if (expected_blocks.size() == 0) begin
            report($sformatf("result %h with no transaction pending", got));
         end else begin
            want = expected_blocks.pop_front();
            if (got !== want)
               report($sformatf("result_block got %h expected %h", got, want));
         end
      endtask
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_wr_en = 1'b0;
   logic [BlockW-1:0] csr_wr_data = '0;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [1:0]        req_action = ACT_NONE;
   logic [2:0]        req_table_select = '0;
   logic [7:0]        req_table_index = '0;
   logic [7:0]        req_table_value = '0;
   logic [BlockW-1:0] req_block_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [BlockW-1:0] rsp_result_block;

   int               send_idle_pct = 0;
   int               stall_pct = 0;
   int               quiet_cycles = 0;
   cipher_scoreboard sb = new;

   sbox_rotate_block_cipher_unit #(.ROUNDS(CIPHER_ROUNDS)) dut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_table_select (req_table_select),
      .req_table_index  (req_table_index),
      .req_table_value  (req_table_value),
      .req_block_data   (req_block_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_block (rsp_result_block)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Receiver back-pressure at the rate of the current phase.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // Result monitor.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_result_block);
   end

   // Watchdog: ends the run after too many cycles without any transaction.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic logic [BlockW-1:0] rand_block();
      return {$urandom, $urandom};
   endfunction

   // Offers one input transaction, after a random gap, and records it once accepted.
   task automatic send(input action_type act, input logic [2:0] lane, input byte_type idx,
                       input byte_type val, input logic [BlockW-1:0] blk);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_action       <= act;
      req_table_select <= lane;
      req_table_index  <= idx;
      req_table_value  <= val;
      req_block_data   <= blk;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(act, lane, idx, val, blk);
   endtask

   task automatic load_entry(input logic [2:0] lane, input byte_type idx, input byte_type val);
      send(ACT_LOAD, lane, idx, val, rand_block());
   endtask

   // Block transactions carry random junk in the table fields.
   task automatic crypt(input action_type act, input logic [BlockW-1:0] blk);
      send(act, 3'($urandom_range(7)), 8'($urandom_range(255)), 8'($urandom_range(255)), blk);
   endtask

   // Fills one lane table with a fresh random permutation.
   task automatic load_permutation(input logic [2:0] lane);
      byte_type perm[TableSize];
      byte_type t;
      int       j;
      for (int i = 0; i < TableSize; i++) perm[i] = byte_type'(i);
      for (int i = TableSize - 1; i > 0; i--) begin
         j = $urandom_range(i);
         t = perm[i];
         perm[i] = perm[j];
         perm[j] = t;
      end
      for (int i = 0; i < TableSize; i++) load_entry(lane, byte_type'(i), perm[i]);
   endtask

   // Holds the sender off until every predicted result has arrived.
   task automatic hold_until_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (sb.expected_blocks.size() != 0);
      @(posedge clock);
   endtask

   // Key writes happen only with the block idle.
   task automatic write_key(input logic [BlockW-1:0] k);
      hold_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= k;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.cipher_key = k;
   endtask

   task automatic run_random(input int count);
      logic [2:0] lane;
      byte_type   i, j, a, b;
      int         pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         lane = 3'($urandom_range(7));
         i = 8'($urandom_range(255));
         j = 8'($urandom_range(255));
         if (pick < 33) begin
            crypt(ACT_ENCRYPT, rand_block());
         end else if (pick < 53) begin
            crypt(ACT_DECRYPT, rand_block());
         end else if (pick < 70) begin
            // Round trip: decrypt a ciphertext of the current tables and key.
            crypt(ACT_DECRYPT, sb.encrypt_block(rand_block()));
         end else if (pick < 75) begin
            crypt(ACT_NONE, rand_block());
         end else if (pick < 86) begin
            // Swap two entries so the table stays a permutation.
            a = sb.fwd_table[{lane, i}];
            b = sb.fwd_table[{lane, j}];
            load_entry(lane, i, b);
            load_entry(lane, j, a);
         end else if (pick < 94) begin
            // Lone load that usually breaks the permutation.
            load_entry(lane, i, j);
         end else if (pick < 97) begin
            hold_until_drained();
         end else begin
            load_permutation(lane);
         end
      end
   endtask

   initial begin
      logic [BlockW-1:0] edge_blocks[4];
      logic [BlockW-1:0] phase_keys[8];
      int                send_pcts[4];
      int                stall_pcts[4];

      edge_blocks = '{'0, '1, 64'h8000_0000_0000_0001, 64'h0123_4567_89AB_CDEF};
      phase_keys  = '{'0, rand_block(), 64'hAAAA_AAAA_AAAA_AAAA, rand_block(),
                      64'h5555_5555_5555_5555, rand_block(), '1, rand_block()};
      send_pcts   = '{0, 62, 0, 23};
      stall_pcts  = '{0, 0, 62, 23};

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Every table entry is written before any block transaction reads it.
      for (int lane = 0; lane < LaneCount; lane++) load_permutation(3'(lane));

      // Directed blocks with the reset key.
      foreach (edge_blocks[k]) crypt(ACT_ENCRYPT, edge_blocks[k]);
      foreach (edge_blocks[k]) crypt(ACT_DECRYPT, edge_blocks[k]);
      crypt(ACT_DECRYPT, sb.encrypt_block(rand_block()));
      send(ACT_NONE, 3'd7, 8'hFF, 8'hFF, '1);
      send(ACT_NONE, 3'd0, 8'h00, 8'h00, '0);

      // Directed blocks with an all-ones key.
      write_key('1);
      crypt(ACT_ENCRYPT, '0);
      crypt(ACT_DECRYPT, '1);
      crypt(ACT_DECRYPT, sb.encrypt_block(64'h0123_4567_89AB_CDEF));

      // Non-permutation table: a duplicated forward value leaves a stale inverse entry.
      load_entry(3'd3, 8'h10, sb.fwd_table[{3'd3, 8'h20}]);
      load_entry(3'd0, 8'hFF, 8'h00);
      crypt(ACT_ENCRYPT, rand_block());
      crypt(ACT_DECRYPT, rand_block());
      crypt(ACT_DECRYPT, sb.encrypt_block(rand_block()));
      load_permutation(3'd3);
      load_permutation(3'd0);

      // Random phases, each with its own idling and two key settings.
      for (int ph = 0; ph < 4; ph++) begin
         for (int k = 0; k < 2; k++) begin
            write_key(phase_keys[2 * ph + k]);
            send_idle_pct <= send_pcts[ph];
            stall_pct     <= stall_pcts[ph];
            run_random(RANDOM_ITEMS);
         end
      end

      hold_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.expected_blocks.size() != 0) sb.report("expected results left over");
      if (sb.errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/sbr_pkg.sv
rtl/sbr_ram.sv
rtl/sbr_lane.sv
rtl/sbr_merge.sv
rtl/sbox_rotate_block_cipher_unit.sv
tb/sv/tb_sbox_rotate_block_cipher_unit.sv
